### sv/vtm_pkg.sv
// Shared types, widths and codes of the virtual timer multiplexer.
`default_nettype none
package vtm_pkg;

   localparam int DEFAULT_TIMERS = 16;

   localparam int ID_W       = 5;
   localparam int TICK_W     = 32;
   localparam int COUNT_W    = 8;
   localparam int QCOUNT_W   = 6;
   localparam int MASK_W     = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   localparam logic [COUNT_W-1:0] RESET_MAX_INTERVAL = 8'd230;
   localparam logic [COUNT_W-1:0] RESET_MIN_LEAD     = 8'd3;

   // longest rejected repeat period, and the tick count below which a timer is due
   localparam logic [TICK_W-1:0] REPEAT_MIN = 32'd2;
   localparam logic [TICK_W-1:0] DUE_LIMIT  = 32'd3;

   localparam logic KIND_REPEAT  = 1'b0;
   localparam logic KIND_ONESHOT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INTERVAL = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEAD     = 4'd1;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_FIRE  = 2'd2,
      OP_POP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_REJECT   = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [TICK_W-1:0] reload;
      logic [TICK_W-1:0] rem;
   } entry_type;

   typedef struct packed {
      logic [TICK_W-1:0]  a;
      logic [TICK_W-1:0]  b;
      logic               sub;
      logic [COUNT_W-1:0] bound;
   } alu_op_type;

   typedef struct packed {
      logic [TICK_W-1:0] sum;
      logic              ult;
      logic              slt;
   } alu_res_type;

endpackage
`default_nettype wire

### sv/vtm_req_if.sv
// Request channel of the virtual timer multiplexer.
`default_nettype none
interface vtm_req_if;
   logic                          valid;
   logic                          ready;
   vtm_pkg::op_type               operation;
   logic [vtm_pkg::ID_W-1:0]      timer_id;
   logic                          timer_type;
   logic [vtm_pkg::TICK_W-1:0]    interval;
   logic [vtm_pkg::COUNT_W-1:0]   counter_value;

   modport source (output valid, operation, timer_id, timer_type, interval, counter_value,
                   input ready);
   modport sink (input valid, operation, timer_id, timer_type, interval, counter_value,
                 output ready);
endinterface
`default_nettype wire

### sv/vtm_rsp_if.sv
// Response channel of the virtual timer multiplexer.
`default_nettype none
interface vtm_rsp_if;
   logic                          valid;
   logic                          ready;
   vtm_pkg::status_type           status;
   logic [vtm_pkg::ID_W-1:0]      fired_id;
   logic [vtm_pkg::COUNT_W-1:0]   compare_interval;
   logic [vtm_pkg::MASK_W-1:0]    active_mask;
   logic [vtm_pkg::QCOUNT_W-1:0]  queue_count;

   modport source (output valid, status, fired_id, compare_interval, active_mask, queue_count,
                   input ready);
   modport sink (input valid, status, fired_id, compare_interval, active_mask, queue_count,
                 output ready);
endinterface
`default_nettype wire

### sv/vtm_csr_if.sv
// Register write channel of the virtual timer multiplexer.
`default_nettype none
interface vtm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [vtm_pkg::CSR_IDX_W-1:0]   index;
   logic [vtm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/vtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/vtm_alu.sv
// Shared 32-bit add/subtract unit with a compare of the result against an 8-bit bound.
`default_nettype none
module vtm_alu (
   input  wire vtm_pkg::alu_op_type  op,
   output vtm_pkg::alu_res_type      res
);

   logic [vtm_pkg::TICK_W-1:0] b_eff;
   logic [vtm_pkg::TICK_W-1:0] sum;

   always_comb begin
      b_eff = op.sub ? ~op.b : op.b;
      sum   = op.a + b_eff + vtm_pkg::TICK_W'(op.sub);
      res.sum = sum;
      res.ult = sum < vtm_pkg::TICK_W'(op.bound);
      // bound is never negative, so a negative sum is always signed-below it
      res.slt = sum[vtm_pkg::TICK_W-1] | (sum < vtm_pkg::TICK_W'(op.bound));
   end

endmodule
`default_nettype wire

### sv/virtual_timer_multiplexer.sv
// Virtual timer multiplexer top level: sequencer, timer and fire-queue stores, response register.
// Start and stop: S_START or S_STOP, then S_OUT, which waits for a free response register and fills it.
// Pop: S_POP_WAIT, S_POP_TAKE, then S_OUT (one registered queue read).
// Fire: one pass over the entries, skipping idle ones; the shared adder charges and reloads each active one.
// One request at a time: the next is taken once the response has been registered.
// Synchronous reset: no timer active, empty queue, compare and max_interval 230, min_lead 3.
`default_nettype none
module virtual_timer_multiplexer #(
   parameter int TIMERS = vtm_pkg::DEFAULT_TIMERS
) (
   input wire logic clock,
   input wire logic reset,
   vtm_req_if.sink  req_ch,
   vtm_rsp_if.source rsp_ch,
   vtm_csr_if.sink  csr_ch
);

   localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int CNT_W = $clog2(TIMERS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMERS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_STOP,
      S_POP_WAIT,
      S_POP_TAKE,
      S_F_READ,
      S_F_SUB,
      S_F_ADJ,
      S_F_END,
      S_OUT
   } state_type;

   // ---------------------------------------------------------------- registers
   state_type                         state_ff, state_in;
   logic [vtm_pkg::ID_W-1:0]          id_ff, id_in;
   logic                              kind_req_ff, kind_req_in;
   logic [vtm_pkg::TICK_W-1:0]        ivl_ff, ivl_in;
   logic [vtm_pkg::COUNT_W-1:0]       cnt_ff, cnt_in;

   logic [vtm_pkg::COUNT_W-1:0]       max_int_ff, max_int_in;
   logic [vtm_pkg::COUNT_W-1:0]       min_lead_ff, min_lead_in;
   logic [vtm_pkg::COUNT_W-1:0]       cc_ff, cc_in;
   logic [vtm_pkg::MASK_W-1:0]        active_ff, active_in;
   logic [IDX_W-1:0]                  head_ff, head_in;
   logic [CNT_W-1:0]                  qsize_ff, qsize_in;

   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic [vtm_pkg::TICK_W-1:0]        diff_ff, diff_in;
   logic                              kind_ff, kind_in;
   logic [vtm_pkg::TICK_W-1:0]        reload_ff, reload_in;
   logic [vtm_pkg::COUNT_W-1:0]       min_ff, min_in;
   vtm_pkg::status_type               status_ff, status_in;
   logic [vtm_pkg::ID_W-1:0]          fired_ff, fired_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   vtm_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [vtm_pkg::ID_W-1:0]          rsp_fired_ff, rsp_fired_in;
   logic [vtm_pkg::COUNT_W-1:0]       rsp_cc_ff, rsp_cc_in;
   logic [vtm_pkg::MASK_W-1:0]        rsp_mask_ff, rsp_mask_in;
   logic [vtm_pkg::QCOUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // ---------------------------------------------------------------- stores
   logic                              tram_wr_en;
   logic [IDX_W-1:0]                  tram_wr_addr;
   vtm_pkg::entry_type                tram_wr_data;
   vtm_pkg::entry_type                tram_rd_data;

   logic                              qram_wr_en;
   logic [IDX_W-1:0]                  qram_wr_addr;
   logic [vtm_pkg::ID_W-1:0]          qram_rd_data;

   vtm_pkg::alu_op_type               alu_op;
   vtm_pkg::alu_res_type              alu_res;

   // per-timer state: kind, reload period and remaining ticks in one word
   vtm_ram #(
      .WIDTH ($bits(vtm_pkg::entry_type)),
      .DEPTH (TIMERS)
   ) u_timer_ram (
      .clock   (clock),
      .wr_en   (tram_wr_en),
      .wr_addr (tram_wr_addr),
      .wr_data (tram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (tram_rd_data)
   );

   // fired-id ring; always read at the head
   vtm_ram #(
      .WIDTH (vtm_pkg::ID_W),
      .DEPTH (TIMERS)
   ) u_fire_queue (
      .clock   (clock),
      .wr_en   (qram_wr_en),
      .wr_addr (qram_wr_addr),
      .wr_data (vtm_pkg::ID_W'(idx_ff)),
      .rd_addr (head_ff),
      .rd_data (qram_rd_data)
   );

   vtm_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   // ---------------------------------------------------------------- handshakes
   logic req_take;
   logic csr_take;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_take     = csr_ch.valid && csr_ch.ready;

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.fired_id         = rsp_fired_ff;
   assign rsp_ch.compare_interval = rsp_cc_ff;
   assign rsp_ch.active_mask      = rsp_mask_ff;
   assign rsp_ch.queue_count      = rsp_count_ff;

   // ---------------------------------------------------------------- helpers
   logic                        id_ok;
   logic [CNT_W:0]              tail_sum;
   logic [IDX_W-1:0]            tail;
   logic                        due;
   logic                        keep;
   logic [vtm_pkg::COUNT_W:0]   floor_sum;
   logic [vtm_pkg::COUNT_W-1:0] floor_val;
   logic [vtm_pkg::COUNT_W:0]   charge;

   always_comb begin
      id_ok = {1'b0, id_ff} < (vtm_pkg::ID_W + 1)'(TIMERS);

      // tail = (head + size) mod TIMERS; the sum stays below twice TIMERS
      tail_sum = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(qsize_ff);
      if (tail_sum >= (CNT_W + 1)'(TIMERS)) begin
         tail = IDX_W'(tail_sum - (CNT_W + 1)'(TIMERS));
      end else begin
         tail = IDX_W'(tail_sum);
      end

      due  = $signed(diff_ff) < $signed(vtm_pkg::DUE_LIMIT);
      keep = !(due && (kind_ff == vtm_pkg::KIND_ONESHOT));

      // lead over the free counter saturates at the top of the 8-bit range
      floor_sum = {1'b0, cnt_ff} + {1'b0, min_lead_ff};
      floor_val = floor_sum[vtm_pkg::COUNT_W] ? '1 : floor_sum[vtm_pkg::COUNT_W-1:0];

      charge = {1'b0, cc_ff} + (vtm_pkg::COUNT_W + 1)'(1);
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      id_in         = id_ff;
      kind_req_in   = kind_req_ff;
      ivl_in        = ivl_ff;
      cnt_in        = cnt_ff;
      max_int_in    = max_int_ff;
      min_lead_in   = min_lead_ff;
      cc_in         = cc_ff;
      active_in     = active_ff;
      head_in       = head_ff;
      qsize_in      = qsize_ff;
      idx_in        = idx_ff;
      diff_in       = diff_ff;
      kind_in       = kind_ff;
      reload_in     = reload_ff;
      min_in        = min_ff;
      status_in     = status_ff;
      fired_in      = fired_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_cc_in     = rsp_cc_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_count_in  = rsp_count_ff;

      tram_wr_en    = 1'b0;
      tram_wr_addr  = idx_ff;
      tram_wr_data  = '{kind: kind_ff, reload: reload_ff, rem: alu_res.sum};
      qram_wr_en    = 1'b0;
      qram_wr_addr  = tail;

      alu_op = '{a: diff_ff, b: '0, sub: 1'b0, bound: min_ff};

      // the user must send configuration writes only while idle; the block itself does not enforce it
      if (csr_take) begin
         case (csr_ch.index)
            vtm_pkg::CSR_MAX_INTERVAL: max_int_in  = csr_ch.data;
            vtm_pkg::CSR_MIN_LEAD:     min_lead_in = csr_ch.data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               id_in       = req_ch.timer_id;
               kind_req_in = req_ch.timer_type;
               ivl_in      = req_ch.interval;
               cnt_in      = req_ch.counter_value;
               status_in   = vtm_pkg::STAT_OK;
               fired_in    = '0;
               idx_in      = '0;
               min_in      = max_int_ff;
               case (req_ch.operation)
                  vtm_pkg::OP_START: state_in = S_START;
                  vtm_pkg::OP_STOP:  state_in = S_STOP;
                  vtm_pkg::OP_FIRE:  state_in = S_F_READ;
                  vtm_pkg::OP_POP:   state_in = S_POP_WAIT;
                  default:           state_in = S_IDLE;
               endcase
            end
         end

         S_START: begin
            // remaining = interval + counter; shorten the compare if it falls below
            alu_op = '{a: ivl_ff, b: vtm_pkg::TICK_W'(cnt_ff), sub: 1'b0, bound: cc_ff};
            if (!id_ok || (kind_req_ff == vtm_pkg::KIND_REPEAT && ivl_ff <= vtm_pkg::REPEAT_MIN))
            begin
               status_in = vtm_pkg::STAT_REJECT;
            end else begin
               tram_wr_en   = 1'b1;
               tram_wr_addr = IDX_W'(id_ff);
               tram_wr_data = '{kind: kind_req_ff, reload: ivl_ff, rem: alu_res.sum};
               active_in[id_ff] = 1'b1;
               if (alu_res.ult) begin
                  cc_in = alu_res.sum[vtm_pkg::COUNT_W-1:0];
               end
            end
            state_in = S_OUT;
         end

         S_STOP: begin
            if (!id_ok || !active_ff[id_ff]) begin
               status_in = vtm_pkg::STAT_REJECT;
            end else begin
               active_in[id_ff] = 1'b0;
            end
            state_in = S_OUT;
         end

         S_POP_WAIT: begin
            // head entry is read this cycle
            state_in = S_POP_TAKE;
         end

         S_POP_TAKE: begin
            if (qsize_ff == '0) begin
               status_in = vtm_pkg::STAT_EMPTY;
            end else begin
               fired_in = qram_rd_data;
               head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
               qsize_in = qsize_ff - CNT_W'(1);
            end
            state_in = S_OUT;
         end

         S_F_READ: begin
            // skip idle entries here; the read of this entry is in flight
            if (active_ff[vtm_pkg::ID_W'(idx_ff)]) begin
               state_in = S_F_SUB;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_F_END;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         S_F_SUB: begin
            // charge compare+1 ticks
            alu_op = '{a: tram_rd_data.rem, b: vtm_pkg::TICK_W'(charge), sub: 1'b1,
                       bound: min_ff};
            diff_in   = alu_res.sum;
            kind_in   = tram_rd_data.kind;
            reload_in = tram_rd_data.reload;
            state_in  = S_F_ADJ;
         end

         S_F_ADJ: begin
            // reload a due repeating timer, queue a due id, write back, and fold into the minimum
            alu_op = '{a: diff_ff,
                       b: (due && kind_ff == vtm_pkg::KIND_REPEAT) ? reload_ff : '0,
                       sub: 1'b0, bound: min_ff};
            tram_wr_en = 1'b1;
            if (due) begin
               if (kind_ff == vtm_pkg::KIND_ONESHOT) begin
                  active_in[vtm_pkg::ID_W'(idx_ff)] = 1'b0;
               end
               if (qsize_ff < CNT_W'(TIMERS)) begin
                  qram_wr_en = 1'b1;
                  qsize_in   = qsize_ff + CNT_W'(1);
               end else begin
                  status_in = vtm_pkg::STAT_OVERFLOW;
               end
            end
            if (keep && alu_res.slt) begin
               min_in = alu_res.sum[vtm_pkg::TICK_W-1] ? '0 :
                        alu_res.sum[vtm_pkg::COUNT_W-1:0];
            end
            if (idx_ff == LAST_IDX) begin
               state_in = S_F_END;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_F_READ;
            end
         end

         S_F_END: begin
            // nearest deadline, held to the lead over the free counter; max_interval if no timer is active
            if (active_ff != '0) begin
               cc_in = (min_ff < floor_val) ? floor_val : min_ff;
            end else begin
               cc_in = max_int_ff;
            end
            state_in = S_OUT;
         end

         S_OUT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_fired_in  = fired_ff;
               rsp_cc_in     = cc_ff;
               rsp_mask_in   = active_ff;
               rsp_count_in  = vtm_pkg::QCOUNT_W'(qsize_ff);
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_int_ff   <= vtm_pkg::RESET_MAX_INTERVAL;
         min_lead_ff  <= vtm_pkg::RESET_MIN_LEAD;
         cc_ff        <= vtm_pkg::RESET_MAX_INTERVAL;
         active_ff    <= '0;
         head_ff      <= '0;
         qsize_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_mask_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         max_int_ff   <= max_int_in;
         min_lead_ff  <= min_lead_in;
         cc_ff        <= cc_in;
         active_ff    <= active_in;
         head_ff      <= head_in;
         qsize_ff     <= qsize_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_mask_ff  <= rsp_mask_in;
      end
      id_ff         <= id_in;
      kind_req_ff   <= kind_req_in;
      ivl_ff        <= ivl_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      diff_ff       <= diff_in;
      kind_ff       <= kind_in;
      reload_ff     <= reload_in;
      min_ff        <= min_in;
      status_ff     <= status_in;
      fired_ff      <= fired_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_cc_ff     <= rsp_cc_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ---------------------------------------------------------------- assertions
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qsize_ff <= CNT_W'(TIMERS))
      else $error("fire queue holds more ids than timers");

   a_mask_range: assert property (@(posedge clock) disable iff (reset)
      (active_ff >> TIMERS) == '0)
      else $error("active bit set beyond the timer count");

   a_queue_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (qsize_ff == $past(qsize_ff) || qsize_ff == $past(qsize_ff) + CNT_W'(1) ||
                qsize_ff + CNT_W'(1) == $past(qsize_ff)))
      else $error("queue size moved by more than one in a cycle");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside the output state");

   a_busy_holds_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_OUT && state_ff != S_IDLE) |=> (rsp_mask_ff == $past(rsp_mask_ff)))
      else $error("response register changed while a request was in progress");

endmodule
`default_nettype wire

### bench/virtual_timer_multiplexer_tb.sv
// Self-checking bench for the virtual timer multiplexer: predicted against actual replies.
`default_nettype none
module virtual_timer_multiplexer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vtm_pkg::*;

   localparam int TIMERS = DEFAULT_TIMERS;

   // One request as driven onto the request channel.
   typedef struct packed {
      op_type               op;
      logic [ID_W-1:0]      timer_id;
      logic                 timer_type;
      logic [TICK_W-1:0]    interval;
      logic [COUNT_W-1:0]   counter_value;
   } timer_cmd_type;

   // One reply as expected on the response channel.
   typedef struct packed {
      status_type           status;
      logic [ID_W-1:0]      fired_id;
      logic [COUNT_W-1:0]   compare_interval;
      logic [MASK_W-1:0]    active_mask;
      logic [QCOUNT_W-1:0]  queue_count;
   } timer_reply_type;

   logic clock;
   logic reset;

   vtm_req_if req_ch();
   vtm_rsp_if rsp_ch();
   vtm_csr_if csr_ch();

   virtual_timer_multiplexer #(
      .TIMERS(TIMERS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Requests waiting to be driven, replies waiting to arrive.
   timer_cmd_type   cmd_fifo[$];
   timer_reply_type reply_fifo[$];

   int unsigned sent_count;
   int unsigned taken_count;
   int unsigned queued_total;
   int unsigned fail_count;
   int unsigned reply_count;
   int unsigned op_seen[4];
   int unsigned status_seen[4];
   int unsigned reg_writes;

   // Percentage of cycles on which each side holds off.
   int unsigned send_gap_pct;
   int unsigned ready_gap_pct;

   // Shadow copy of the block's registers and timer state.
   logic [COUNT_W-1:0] max_interval_m;
   logic [COUNT_W-1:0] min_lead_m;
   logic [MASK_W-1:0]  active_m;
   logic               kind_m   [TIMERS];
   logic [TICK_W-1:0]  reload_m [TIMERS];
   logic [TICK_W-1:0]  remain_m [TIMERS];
   logic [COUNT_W-1:0] compare_m;
   logic [ID_W-1:0]    fired_m  [TIMERS];
   int unsigned        head_m;
   int unsigned        fill_m;

   // Clock: 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the shadow state by one request and return the reply it should produce.
   function automatic timer_reply_type apply_timer_cmd(input timer_cmd_type c);
      timer_reply_type    r;
      logic [TICK_W-1:0]  rem;
      logic [TICK_W-1:0]  charge;
      logic [TICK_W-1:0]  best;
      logic [TICK_W-1:0]  lead;
      r.status   = STAT_OK;
      r.fired_id = '0;
      case (c.op)
         OP_START: begin
            if (c.timer_id >= TIMERS ||
                (c.timer_type == KIND_REPEAT && c.interval <= REPEAT_MIN)) begin
               r.status = STAT_REJECT;
            end else begin
               rem = c.interval + {24'd0, c.counter_value};
               reload_m[c.timer_id] = c.interval;
               kind_m[c.timer_id]   = c.timer_type;
               remain_m[c.timer_id] = rem;
               active_m[c.timer_id] = 1'b1;
               // a start may only pull the compare in, judged unsigned
               if (rem < {24'd0, compare_m})
                  compare_m = rem[COUNT_W-1:0];
            end
         end
         OP_STOP: begin
            if (c.timer_id >= TIMERS || !active_m[c.timer_id])
               r.status = STAT_REJECT;
            else
               active_m[c.timer_id] = 1'b0;
         end
         OP_FIRE: begin
            charge = {24'd0, compare_m} + 32'd1;
            for (int i = 0; i < TIMERS; i++) begin
               if (active_m[i]) begin
                  remain_m[i] = remain_m[i] - charge;
                  if ($signed(remain_m[i]) < $signed(DUE_LIMIT)) begin
                     if (kind_m[i] == KIND_REPEAT)
                        remain_m[i] = remain_m[i] + reload_m[i];
                     else
                        active_m[i] = 1'b0;
                     // full queue: drop the id but keep the reload or stop
                     if (fill_m >= TIMERS) begin
                        r.status = STAT_OVERFLOW;
                     end else begin
                        fired_m[(head_m + fill_m) % TIMERS] = ID_W'(i);
                        fill_m++;
                     end
                  end
               end
            end
            best = {24'd0, max_interval_m};
            if (active_m != '0) begin
               for (int i = 0; i < TIMERS; i++) begin
                  // negative counts take part in the search as zero
                  if (active_m[i] && $signed(remain_m[i]) < $signed(best))
                     best = remain_m[i][TICK_W-1] ? '0 : remain_m[i];
               end
               lead = {24'd0, c.counter_value} + {24'd0, min_lead_m};
               if (lead > 32'd255)
                  lead = 32'd255;
               if (best < lead)
                  best = lead;
            end
            compare_m = best[COUNT_W-1:0];
         end
         OP_POP: begin
            if (fill_m == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.fired_id = fired_m[head_m];
               head_m = (head_m + 1) % TIMERS;
               fill_m--;
            end
         end
      endcase
      r.compare_interval = compare_m;
      r.active_mask      = active_m;
      r.queue_count      = QCOUNT_W'(fill_m);
      return r;
   endfunction

   // Driver: present the next request at the falling edge, hold it until it is taken.
   always @(negedge clock) begin
      timer_cmd_type c;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!(req_ch.valid && sent_count != taken_count)) begin
         if (cmd_fifo.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
            c = cmd_fifo.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.operation     <= c.op;
            req_ch.timer_id      <= c.timer_id;
            req_ch.timer_type    <= c.timer_type;
            req_ch.interval      <= c.interval;
            req_ch.counter_value <= c.counter_value;
            sent_count           <= sent_count + 1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Back-pressure on the response side, also at the falling edge.
   always @(negedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= ready_gap_pct);
   end

   // Monitor: predict on every accepted request, check every accepted reply.
   always @(posedge clock) begin
      timer_cmd_type   c;
      timer_reply_type e;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            c.op            = req_ch.operation;
            c.timer_id      = req_ch.timer_id;
            c.timer_type    = req_ch.timer_type;
            c.interval      = req_ch.interval;
            c.counter_value = req_ch.counter_value;
            e = apply_timer_cmd(c);
            reply_fifo.push_back(e);
            op_seen[c.op]++;
            status_seen[e.status]++;
            taken_count <= taken_count + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            reply_count++;
            if (reply_fifo.size() == 0) begin
               $error("reply with no request outstanding: status %0d", rsp_ch.status);
               fail_count++;
            end else begin
               e = reply_fifo.pop_front();
               if (rsp_ch.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_ch.status);
                  fail_count++;
               end
               if (rsp_ch.fired_id !== e.fired_id) begin
                  $error("fired_id: expected %0d, got %0d", e.fired_id, rsp_ch.fired_id);
                  fail_count++;
               end
               if (rsp_ch.compare_interval !== e.compare_interval) begin
                  $error("compare_interval: expected %0d, got %0d",
                         e.compare_interval, rsp_ch.compare_interval);
                  fail_count++;
               end
               if (rsp_ch.active_mask !== e.active_mask) begin
                  $error("active_mask: expected %h, got %h", e.active_mask, rsp_ch.active_mask);
                  fail_count++;
               end
               if (rsp_ch.queue_count !== e.queue_count) begin
                  $error("queue_count: expected %0d, got %0d",
                         e.queue_count, rsp_ch.queue_count);
                  fail_count++;
               end
            end
         end
      end
   end

   // Append one request to the pending list.
   function automatic void queue_cmd(input op_type op, input int unsigned id,
                                     input logic kind, input logic [TICK_W-1:0] ivl,
                                     input int unsigned cnt);
      timer_cmd_type c;
      c.op            = op;
      c.timer_id      = ID_W'(id);
      c.timer_type    = kind;
      c.interval      = ivl;
      c.counter_value = COUNT_W'(cnt);
      cmd_fifo.push_back(c);
      queued_total++;
   endfunction

   // Random requests: mostly well-formed traffic, some queue-filling bursts, some noise.
   task automatic add_random_cmds(input int unsigned count, input bit open_with_fill);
      int unsigned start_total;
      int unsigned pick;
      int unsigned sel;
      int unsigned reps;
      logic [TICK_W-1:0] ivl;
      bit fill_next;
      start_total = queued_total;
      fill_next   = open_with_fill;
      while (queued_total - start_total < count) begin
         pick      = fill_next ? 0 : $urandom_range(99);
         fill_next = 1'b0;
         if (pick < 12) begin
            // start every timer on a short repeat, fire without popping to overrun the queue
            for (int i = 0; i < TIMERS; i++)
               queue_cmd(OP_START, i, KIND_REPEAT, $urandom_range(3, 20), $urandom_range(255));
            reps = $urandom_range(3, 5);
            repeat (reps) queue_cmd(OP_FIRE, 0, 1'b0, $urandom(), $urandom_range(255));
            reps = $urandom_range(1, 20);
            repeat (reps) queue_cmd(OP_POP, $urandom_range(31), 1'($urandom_range(1)),
                                    $urandom(), $urandom_range(255));
         end else if (pick < 75) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
               case ($urandom_range(9))
                  0:       ivl = $urandom();
                  1, 2:    ivl = $urandom_range(3, 20);
                  default: ivl = $urandom_range(3, 400);
               endcase
               queue_cmd(OP_START, $urandom_range(TIMERS - 1), 1'($urandom_range(1)), ivl,
                         $urandom_range(255));
            end else if (sel < 60) begin
               queue_cmd(OP_FIRE, $urandom_range(31), 1'($urandom_range(1)), $urandom(),
                         $urandom_range(255));
            end else if (sel < 85) begin
               queue_cmd(OP_POP, $urandom_range(31), 1'($urandom_range(1)), $urandom(),
                         $urandom_range(255));
            end else begin
               queue_cmd(OP_STOP, $urandom_range(TIMERS - 1), 1'($urandom_range(1)),
                         $urandom(), $urandom_range(255));
            end
         end else begin
            // noise: out-of-range ids, too-short repeats, anything at all
            ivl = $urandom_range(1) ? $urandom() : $urandom_range(2);
            queue_cmd(op_type'($urandom_range(3)), $urandom_range(31), 1'($urandom_range(1)),
                      ivl, $urandom_range(255));
         end
      end
   endtask

   // Wait until every request has been taken and answered, then let the block settle.
   task automatic wait_drained();
      while (cmd_fifo.size() != 0 || sent_count != taken_count || reply_fifo.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register while the block is idle and mirror it in the shadow copy.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_MAX_INTERVAL)
         max_interval_m = value;
      else if (idx == CSR_MIN_LEAD)
         min_lead_m = value;
      reg_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Change both registers between phases, once the block has gone quiet.
   task automatic run_phase(input logic [7:0] max_ivl, input logic [7:0] lead,
                            input int unsigned gap_pct, input int unsigned count,
                            input bit open_with_fill);
      wait_drained();
      write_reg(CSR_MAX_INTERVAL, max_ivl);
      write_reg(CSR_MIN_LEAD, lead);
      send_gap_pct  = gap_pct;
      ready_gap_pct = gap_pct;
      add_random_cmds(count, open_with_fill);
   endtask

   // Stimulus and end of run.
   initial begin
      // Drive every input to a known value before the first edge.
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.operation     = OP_START;
      req_ch.timer_id      = '0;
      req_ch.timer_type    = 1'b0;
      req_ch.interval      = '0;
      req_ch.counter_value = '0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.data          = '0;
      sent_count    = 0;
      taken_count   = 0;
      queued_total  = 0;
      fail_count    = 0;
      reply_count   = 0;
      reg_writes    = 0;
      send_gap_pct  = 38;
      ready_gap_pct = 38;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;

      // Shadow state after reset; the stores are never read before being written.
      max_interval_m = RESET_MAX_INTERVAL;
      min_lead_m     = RESET_MIN_LEAD;
      active_m       = '0;
      compare_m      = RESET_MAX_INTERVAL;
      head_m         = 0;
      fill_m         = 0;
      foreach (kind_m[i]) begin
         kind_m[i]   = 1'b0;
         reload_m[i] = '0;
         remain_m[i] = '0;
         fired_m[i]  = '0;
      end

      // Hold reset, then drop it on a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings.
      queue_cmd(OP_POP,   0,  1'b0, 32'd0, 0);             // pop on an empty queue
      queue_cmd(OP_STOP,  5,  1'b0, 32'd0, 0);             // stop of an idle timer
      queue_cmd(OP_START, 20, KIND_ONESHOT, 32'hFFFF_FFFF, 255);  // id out of range
      queue_cmd(OP_START, 31, KIND_REPEAT, 32'd100, 0);    // top id, out of range
      queue_cmd(OP_START, 0,  KIND_REPEAT, 32'd2, 7);      // repeat period too short
      queue_cmd(OP_START, 15, KIND_ONESHOT, 32'd0, 0);     // zero interval pulls compare to 0
      queue_cmd(OP_START, 0,  KIND_REPEAT, 32'hFFFF_FFFF, 255);   // remaining wraps
      queue_cmd(OP_FIRE,  0,  1'b0, 32'd0, 255);           // lead sum saturates
      queue_cmd(OP_START, 3,  KIND_REPEAT, 32'd3, 0);      // shortest repeat
      queue_cmd(OP_FIRE,  0,  1'b0, 32'd0, 250);           // floor lifts the compare
      queue_cmd(OP_FIRE,  0,  1'b0, 32'd0, 10);            // leaves negative remaining counts
      repeat (5) queue_cmd(OP_POP, 0, 1'b0, 32'd0, 0);     // drain, then one empty pop
      queue_cmd(OP_STOP,  3,  1'b0, 32'd0, 0);
      queue_cmd(OP_STOP,  3,  1'b0, 32'd0, 0);             // second stop is rejected
      queue_cmd(OP_STOP,  16, 1'b1, 32'hFFFF_FFFF, 255);   // stop out of range
      queue_cmd(OP_START, 9,  KIND_ONESHOT, 32'd1, 5);
      queue_cmd(OP_START, 12, KIND_REPEAT, 32'h7FFF_FFFF, 128);   // negative as signed
      queue_cmd(OP_FIRE,  0,  1'b0, 32'd0, 0);
      queue_cmd(OP_FIRE,  31, 1'b1, 32'hFFFF_FFFF, 128);
      queue_cmd(OP_POP,   31, 1'b1, 32'hFFFF_FFFF, 255);
      queue_cmd(OP_STOP,  0,  1'b0, 32'd0, 0);

      // Random phases across the register extremes; one phase runs without any gaps.
      run_phase(8'd255, 8'd0,   38, 230, 1'b1);
      run_phase(8'd1,   8'd255, 38, 200, 1'b0);
      run_phase(8'd100, 8'd20,  0,  250, 1'b1);
      run_phase(8'd17,  8'd1,   38, 230, 1'b0);
      run_phase(8'd230, 8'd3,   38, 240, 1'b1);

      // Drain, then allow for a full fire pass before closing.
      wait_drained();
      repeat (TIMERS * 3 + 10) @(posedge clock);
      if (reply_fifo.size() != 0)
         fail_count++;

      $display("Run covered %0d requests (%0d start, %0d stop, %0d fire, %0d pop), %0d replies.",
               taken_count, op_seen[OP_START], op_seen[OP_STOP], op_seen[OP_FIRE],
               op_seen[OP_POP], reply_count);
      $display("Outcomes: %0d ok, %0d rejected, %0d empty pops, %0d overflows; %0d reg writes.",
               status_seen[STAT_OK], status_seen[STAT_REJECT], status_seen[STAT_EMPTY],
               status_seen[STAT_OVERFLOW], reg_writes);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: end the run if it stalls.
   initial begin
      #10ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire
